// ===== hdl/clac_pkg.sv =====
// clac_pkg: types and constants for the central lock auto-lock controller
// no dependencies; imported by central_lock_autolock_controller
`default_nettype none

package clac_pkg;

  // action codes carried on each result beat
  localparam logic [1:0] ACT_STATUS = 2'd0;
  localparam logic [1:0] ACT_TRUNK  = 2'd1;
  localparam logic [1:0] ACT_LOCK   = 2'd2;
  localparam logic [1:0] ACT_UNLOCK = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY     = 2'd1;

  localparam int unsigned MV_W    = 15;
  localparam int unsigned DELAY_W = 8;

  localparam logic [MV_W-1:0]    THRESHOLD_RESET = 15'd8000;
  localparam logic [DELAY_W-1:0] DELAY_RESET     = 8'd20;

  // fixed result slots of one tick, in emission order
  localparam int unsigned NUM_SLOTS   = 6;
  localparam int unsigned SLOT_IDX_W  = 3;
  localparam logic [SLOT_IDX_W-1:0] SLOT_TRUNK   = 3'd0;
  localparam logic [SLOT_IDX_W-1:0] SLOT_SWITCH  = 3'd1;
  localparam logic [SLOT_IDX_W-1:0] SLOT_RLOCK   = 3'd2;
  localparam logic [SLOT_IDX_W-1:0] SLOT_RUNLOCK = 3'd3;
  localparam logic [SLOT_IDX_W-1:0] SLOT_AUTO    = 3'd4;
  localparam logic [SLOT_IDX_W-1:0] SLOT_STATUS  = 3'd5;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] beeps;
    logic       indicator;
  } slot_t;

endpackage

`default_nettype wire

// ===== hdl/central_lock_autolock_controller.sv =====
// central_lock_autolock_controller: poll-tick lock controller, top level
// depends on clac_pkg (action codes, slot layout, register indexes)
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  item     | item_valid / item_stall| supply_mv, door_open, brake_pressed,
//           |                        | trunk_button, door_switch, remote_lock,
//           |                        | remote_unlock
//  result   | res_valid / res_stall  | action, beeps, indicator, last
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// an item sits in the input register until the result buffer is free; its whole tick is
// then worked out in one pass and drops into a six-slot result buffer, which drains one
// beat a cycle while res_stall is low
// a tick yields 1 to 6 beats, so the item rate follows the output: one item per cycle
// at best; when the output is busy, a new item waits for the previous tick's last beat
// rst is synchronous: lock state returns to unlocked, registers to their defaults
// stalls on the result side back up into item_stall once the input register is full
`default_nettype none

module central_lock_autolock_controller (
  input  wire                            clk,
  input  wire                            rst,
  // item channel
  input  wire                            item_valid,
  output logic                           item_stall,
  input  wire  [clac_pkg::MV_W-1:0]      supply_mv,
  input  wire                            door_open,
  input  wire                            brake_pressed,
  input  wire                            trunk_button,
  input  wire                            door_switch,
  input  wire                            remote_lock,
  input  wire                            remote_unlock,
  // result channel
  output logic                           res_valid,
  input  wire                            res_stall,
  output logic [1:0]                     action,
  output logic [1:0]                     beeps,
  output logic                           indicator,
  output logic                           last,
  // configuration channel
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [clac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [clac_pkg::MV_W-1:0]      cfg_data
);
  import clac_pkg::*;

  // configuration registers
  logic [MV_W-1:0]    threshold;
  logic [DELAY_W-1:0] lock_delay;

  // lock state
  logic               doors_unlocked, doors_unlocked_next;
  logic               driver_present, driver_present_next;
  logic               brake_hold, brake_hold_next;
  logic [DELAY_W-1:0] delay_count, delay_count_next;

  // input register
  logic               pend_valid;
  logic [MV_W-1:0]    pend_supply;
  logic               pend_door, pend_brake, pend_trunk, pend_sw, pend_rlock, pend_runlock;

  // result buffer
  slot_t                slot      [NUM_SLOTS];
  slot_t                slot_next [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_valid;
  logic [NUM_SLOTS-1:0] slot_valid_next;
  logic [NUM_SLOTS-1:0] head_mask;
  logic [SLOT_IDX_W-1:0] head_idx;

  logic item_take, res_take, tick_done, load, engine_on;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= THRESHOLD_RESET;
      lock_delay <= DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold  <= cfg_data;
        REG_DELAY:     lock_delay <= cfg_data[DELAY_W-1:0];
        default: ; // writes beyond the register list are dropped
      endcase
    end
  end

  // ---- output side: head slot is the lowest valid one
  assign head_mask = slot_valid & (~slot_valid + 1'b1);

  always_comb begin
    head_idx = SLOT_STATUS;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (head_mask[i]) head_idx = SLOT_IDX_W'(i);
    end
  end

  assign res_valid = |slot_valid;
  assign action    = slot[head_idx].action;
  assign beeps     = slot[head_idx].beeps;
  assign indicator = slot[head_idx].indicator;
  assign last      = ((slot_valid & ~head_mask) == '0);

  assign res_take  = res_valid && !res_stall;
  assign tick_done = res_take && last;

  // a pending tick is evaluated once the buffer is empty or its final beat leaves
  assign load       = pend_valid && (!res_valid || tick_done);
  assign item_stall = pend_valid && !load;
  assign item_take  = item_valid && !item_stall;

  assign engine_on = (pend_supply > threshold);

  // ---- one pass over the tick, in slot order
  always_comb begin
    logic du, dp;
    du = doors_unlocked;
    dp = driver_present;
    brake_hold_next  = brake_hold;
    delay_count_next = delay_count;
    slot_valid_next  = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_next[i] = '{action: ACT_STATUS, beeps: 2'd0, indicator: 1'b0};
    end

    // trunk release only while unlocked
    slot_valid_next[SLOT_TRUNK] = pend_trunk && du;
    slot_next[SLOT_TRUNK] = '{action: ACT_TRUNK, beeps: 2'd0, indicator: du};

    // interior toggle switch
    if (pend_sw) begin
      if (du) begin
        du = 1'b0;
        slot_next[SLOT_SWITCH].action = ACT_LOCK;
      end else begin
        du = 1'b1;
        dp = 1'b0;
        slot_next[SLOT_SWITCH].action = ACT_UNLOCK;
      end
    end
    slot_valid_next[SLOT_SWITCH] = pend_sw;
    slot_next[SLOT_SWITCH].indicator = du;

    // key fob
    if (pend_rlock) du = 1'b0;
    slot_valid_next[SLOT_RLOCK] = pend_rlock;
    slot_next[SLOT_RLOCK] = '{action: ACT_LOCK, beeps: 2'd1, indicator: du};

    if (pend_runlock) du = 1'b1;
    slot_valid_next[SLOT_RUNLOCK] = pend_runlock;
    slot_next[SLOT_RUNLOCK] = '{action: ACT_UNLOCK, beeps: 2'd2, indicator: du};

    // driver-presence logic
    if (engine_on) begin
      if (pend_door) begin
        // doors opened by hand with the engine running
        dp = 1'b0;
        du = 1'b1;
        if (pend_brake) brake_hold_next = 1'b1;
      end else if (!du) begin
        if (pend_brake) brake_hold_next = 1'b1;
      end else begin
        if (!pend_brake) brake_hold_next = 1'b0;
        if (!brake_hold_next && !dp && pend_brake) begin
          if (delay_count < lock_delay) begin
            delay_count_next = delay_count + 1'b1;
          end else begin
            delay_count_next = '0;
            dp = 1'b1;
            du = 1'b0;
            slot_valid_next[SLOT_AUTO] = 1'b1;
            slot_next[SLOT_AUTO].action = ACT_LOCK;
          end
        end
      end
    end else begin
      if (du) dp = 1'b0;
      if (dp) begin
        // engine stopped after an automatic lock
        du = 1'b1;
        slot_valid_next[SLOT_AUTO] = 1'b1;
        slot_next[SLOT_AUTO].action = ACT_UNLOCK;
      end
    end
    slot_next[SLOT_AUTO].indicator = du;

    slot_valid_next[SLOT_STATUS] = 1'b1;
    slot_next[SLOT_STATUS].indicator = du;

    doors_unlocked_next = du;
    driver_present_next = dp;
  end

  // ---- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid     <= 1'b0;
      slot_valid     <= '0;
      doors_unlocked <= 1'b1;
      driver_present <= 1'b0;
      brake_hold     <= 1'b0;
      delay_count    <= '0;
    end else begin
      if (item_take)   pend_valid <= 1'b1;
      else if (load)   pend_valid <= 1'b0;

      if (load) begin
        slot_valid     <= slot_valid_next;
        doors_unlocked <= doors_unlocked_next;
        driver_present <= driver_present_next;
        brake_hold     <= brake_hold_next;
        delay_count    <= delay_count_next;
      end else if (res_take) begin
        slot_valid <= slot_valid & ~head_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      pend_supply  <= supply_mv;
      pend_door    <= door_open;
      pend_brake   <= brake_pressed;
      pend_trunk   <= trunk_button;
      pend_sw      <= door_switch;
      pend_rlock   <= remote_lock;
      pend_runlock <= remote_unlock;
    end
    if (load) begin
      for (int i = 0; i < NUM_SLOTS; i++) slot[i] <= slot_next[i];
    end
  end

`ifndef ASSERT_OFF
  // the status slot closes every buffered tick
  a_status_present: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> slot_valid[SLOT_STATUS])
    else $error("result buffer holds a tick without its status beat");

  // the final beat is the status beat
  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && last) |-> (action == ACT_STATUS && beeps == 2'd0))
    else $error("final beat carries a command");

  // final beat reports the lock state left by its tick
  a_last_indicator: assert property (@(posedge clk) disable iff (rst)
    (res_valid && last) |-> (indicator == doors_unlocked))
    else $error("status indicator differs from lock state");

  // with nothing pending, taking the final beat empties the buffer
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (tick_done && !pend_valid) |=> !res_valid)
    else $error("result beats left after final beat");
`endif

endmodule

`default_nettype wire
